### rtl/polynomial_least_squares_fit_assert.svh
// assertion macros used by the polynomial fit controller
// depends on nothing; included by plsf_ctrl, the only file that checks its own logic
`ifndef POLYNOMIAL_LEAST_SQUARES_FIT_ASSERT_SVH
`define POLYNOMIAL_LEAST_SQUARES_FIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define PLSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plsf check failed");

// condition implies consequence in the next cycle
`define PLSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plsf check failed");

`endif

### rtl/plsf_pkg.sv
// types, constants and small tables of the polynomial fit block
// depends on nothing; used by the controller, datapath and top level
package plsf_pkg;

    // fixed field and accumulator widths
    localparam int XW = 12;
    localparam int YW = 16;
    localparam int SPW = 57;
    localparam int SMW = 50;
    localparam int CFW = 48;

    // register index of num_terms
    localparam logic REG_NUM_TERMS = 1'b0;

    // no column replaced
    localparam logic [1:0] COL_NONE = 2'd3;

    // multiplier partial product count and last permutation
    localparam logic [3:0] MUL_PAIRS = 4'd10;
    localparam logic [2:0] PERM_LAST = 3'd5;

    // divider steps: 128 numerator bits and 16 fraction bits
    localparam logic [7:0] DIV_STEPS = 8'd144;

    // quotient clamps and output limits
    localparam logic [50:0] Q_SAT = 51'd562949953421312;
    localparam logic [50:0] Q_LIM = 51'd140737488355328;
    localparam logic [47:0] COEF_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] COEF_MIN = 48'h8000_0000_0000;

    // datapath command
    typedef struct packed {
        logic       solve_init;
        logic       det_clr;
        logic       load_a;
        logic       mul_start;
        logic       mul_chain;
        logic [1:0] row;
        logic [2:0] perm;
        logic       det_add;
        logic       den_save;
        logic       div_start;
        logic       out_load;
        logic       sing;
        logic [1:0] ord;
        logic [1:0] col;
        logic [1:0] kk;
    } t_dp_cmd;

    // datapath status
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_zero;
    } t_dp_sts;

    // column used by a row in one term of the 3x3 determinant
    function automatic logic [1:0] f_perm_col(input logic [2:0] perm, input logic [1:0] row);
        logic [5:0] cols;
        case (perm)
            3'd0:    cols = {2'd0, 2'd1, 2'd2};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd2, 2'd0, 2'd1};
            3'd5:    cols = {2'd2, 2'd1, 2'd0};
            default: cols = {2'd0, 2'd1, 2'd2};
        endcase
        case (row)
            2'd0:    return cols[5:4];
            2'd1:    return cols[3:2];
            default: return cols[1:0];
        endcase
    endfunction

    // odd permutations subtract
    function automatic logic f_perm_neg(input logic [2:0] perm);
        case (perm)
            3'd1, 3'd2, 3'd5: return 1'b1;
            default:          return 1'b0;
        endcase
    endfunction

    // limb pair {i, j} of a partial product, i + j below four
    function automatic logic [3:0] f_pair(input logic [3:0] idx);
        case (idx)
            4'd0:    return {2'd0, 2'd0};
            4'd1:    return {2'd0, 2'd1};
            4'd2:    return {2'd1, 2'd0};
            4'd3:    return {2'd0, 2'd2};
            4'd4:    return {2'd1, 2'd1};
            4'd5:    return {2'd2, 2'd0};
            4'd6:    return {2'd0, 2'd3};
            4'd7:    return {2'd1, 2'd2};
            4'd8:    return {2'd2, 2'd1};
            4'd9:    return {2'd3, 2'd0};
            default: return {2'd0, 2'd0};
        endcase
    endfunction

endpackage

### rtl/polynomial_least_squares_fit.sv
// top level of the least-squares polynomial fit: config register and wiring
// depends on plsf_pkg, plsf_ctrl and plsf_dp
//
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// in       | i_in_valid / o_in_ready    | i_sample_x, i_sample_y, i_last_sample
// out      | o_out_valid / i_out_ready  | o_coef_const/linear/quad, o_singular,
//          |                            | o_sample_overflow
// config   | psel, penable, pwrite      | paddr, pwdata, prdata (num_terms)
//
// samples are taken one per cycle while o_in_ready is high; sums settle through
// a three-stage product pipeline; a last item adds the drain states S_DRN1 and S_DRN2
// and the solve, where each 3x3 determinant uses the shared 32x32 multiplier and each
// coefficient of a nonsingular system is one division; no item is taken meanwhile
// a finished result waits in the output register while new samples are taken
// reset is synchronous, active low, and clears the sums; no clearing pass
module polynomial_least_squares_fit #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [11:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic               i_last_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_coef_const,
    output logic signed [47:0] o_coef_linear,
    output logic signed [47:0] o_coef_quad,
    output logic               o_singular,
    output logic               o_sample_overflow,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0]        r_num_terms;
    logic              w_acc;
    plsf_pkg::t_dp_cmd w_cmd;
    plsf_pkg::t_dp_sts w_sts;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_terms <= 2'd3;
        end else if (psel && penable && pwrite && paddr[2] == plsf_pkg::REG_NUM_TERMS) begin
            r_num_terms <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == plsf_pkg::REG_NUM_TERMS) ? {30'd0, r_num_terms} : 32'd0;
    assign pready = 1'b1;

    // item accepted
    assign w_acc = i_in_valid & o_in_ready;

    plsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_last      (i_last_sample),
        .i_num_terms (r_num_terms),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    plsf_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (w_acc),
        .i_sample_x        (i_sample_x),
        .i_sample_y        (i_sample_y),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_coef_const      (o_coef_const),
        .o_coef_linear     (o_coef_linear),
        .o_coef_quad       (o_coef_quad),
        .o_singular        (o_singular),
        .o_sample_overflow (o_sample_overflow)
    );

endmodule

### rtl/plsf_ctrl.sv
// solve sequencer: minors, cramer determinants, divisions, result handoff
// depends on plsf_pkg and polynomial_least_squares_fit_assert.svh
`include "polynomial_least_squares_fit_assert.svh"

module plsf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic              i_last,
    input  logic [1:0]        i_num_terms,
    input  logic              i_out_ready,
    input  plsf_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output plsf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_ACC  = 12'b0000_0000_0001,
        S_DRN1 = 12'b0000_0000_0010,
        S_DRN2 = 12'b0000_0000_0100,
        S_LA   = 12'b0000_0000_1000,
        S_M1   = 12'b0000_0001_0000,
        S_W1   = 12'b0000_0010_0000,
        S_M2   = 12'b0000_0100_0000,
        S_W2   = 12'b0000_1000_0000,
        S_ADD  = 12'b0001_0000_0000,
        S_DEND = 12'b0010_0000_0000,
        S_WDIV = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_ord, n_ord;
    logic [1:0] r_col, n_col;
    logic [2:0] r_perm, n_perm;
    logic       r_minor, n_minor;
    logic       r_sing, n_sing;
    logic       r_out_valid, n_out_valid;
    logic [1:0] w_k;
    logic       w_sing;

    // zero terms behaves as one
    assign w_k = (i_num_terms == 2'd0) ? 2'd1 : i_num_terms;
    assign w_sing = r_sing | i_sts.det_zero;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_ord = r_ord;
        n_col = r_col;
        n_perm = r_perm;
        n_minor = r_minor;
        n_sing = r_sing;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd = '0;
        o_cmd.row = 2'd1;
        o_cmd.perm = r_perm;
        o_cmd.ord = r_ord;
        o_cmd.col = r_col;
        o_cmd.kk = w_k;
        o_cmd.sing = r_sing;
        case (r_state)
            S_ACC: begin
                if (i_acc && i_last) n_state = S_DRN1;
            end
            S_DRN1: begin
                n_state = S_DRN2;
            end
            S_DRN2: begin
                o_cmd.solve_init = 1'b1;
                o_cmd.det_clr = 1'b1;
                n_ord = 2'd1;
                n_col = plsf_pkg::COL_NONE;
                n_perm = '0;
                n_minor = 1'b1;
                n_sing = 1'b0;
                n_state = S_LA;
            end
            S_LA: begin
                o_cmd.load_a = 1'b1;
                o_cmd.row = 2'd0;
                n_state = S_M1;
            end
            S_M1: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_W1;
            end
            S_W1: begin
                if (i_sts.mul_done) n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_chain = 1'b1;
                o_cmd.row = 2'd2;
                n_state = S_W2;
            end
            S_W2: begin
                if (i_sts.mul_done) n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.det_add = 1'b1;
                if (r_perm == plsf_pkg::PERM_LAST) begin
                    n_state = S_DEND;
                end else begin
                    n_perm = r_perm + 3'd1;
                    n_state = S_LA;
                end
            end
            S_DEND: begin
                n_perm = '0;
                if (r_minor) begin
                    o_cmd.den_save = 1'b1;
                    n_sing = w_sing;
                    if (r_ord < w_k) begin
                        n_ord = r_ord + 2'd1;
                        o_cmd.det_clr = 1'b1;
                        n_state = S_LA;
                    end else if (w_sing) begin
                        n_state = S_FIN;
                    end else begin
                        n_minor = 1'b0;
                        n_col = 2'd0;
                        o_cmd.det_clr = 1'b1;
                        n_state = S_LA;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                if (i_sts.div_done) begin
                    if (r_col < w_k - 2'd1) begin
                        n_col = r_col + 2'd1;
                        o_cmd.det_clr = 1'b1;
                        n_state = S_LA;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_ord <= 2'd1;
            r_col <= plsf_pkg::COL_NONE;
            r_perm <= '0;
            r_minor <= 1'b1;
            r_sing <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ord <= n_ord;
            r_col <= n_col;
            r_perm <= n_perm;
            r_minor <= n_minor;
            r_sing <= n_sing;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;

    // checks on sequencing
    `PLSF_ASSERT_IMP(a_ready_no_solve, i_clk, i_rst_n, o_in_ready, !(o_cmd.mul_start || o_cmd.div_start))
    `PLSF_ASSERT_IMP(a_mul_done_waiting, i_clk, i_rst_n, i_sts.mul_done, (r_state == S_W1) || (r_state == S_W2))
    `PLSF_ASSERT_IMP(a_div_done_waiting, i_clk, i_rst_n, i_sts.div_done, r_state == S_WDIV)
    `PLSF_ASSERT_NXT(a_load_shows_item, i_clk, i_rst_n, o_cmd.out_load, o_out_valid)

endmodule

### rtl/plsf_dp.sv
// datapath: moment accumulation pipeline, matrix element select,
// 128-bit sequential multiplier, determinant accumulator, divider, result register
// depends on plsf_pkg
module plsf_dp #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_acc,
    input  logic signed [11:0]      i_sample_x,
    input  logic signed [15:0]      i_sample_y,
    input  plsf_pkg::t_dp_cmd       i_cmd,
    output plsf_pkg::t_dp_sts       o_sts,
    output logic signed [47:0]      o_coef_const,
    output logic signed [47:0]      o_coef_linear,
    output logic signed [47:0]      o_coef_quad,
    output logic                    o_singular,
    output logic                    o_sample_overflow
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic          w_take;

    logic               r_s1_vld;
    logic signed [11:0] r_s1_x;
    logic signed [15:0] r_s1_y;
    logic signed [23:0] r_s1_x2;
    logic signed [27:0] r_s1_xy;
    logic               r_s2_vld;
    logic signed [11:0] r_s2_x;
    logic signed [15:0] r_s2_y;
    logic signed [23:0] r_s2_x2;
    logic signed [27:0] r_s2_xy;
    logic signed [35:0] r_s2_x3;
    logic signed [47:0] r_s2_x4;
    logic signed [39:0] r_s2_x2y;

    logic signed [27:0] w_x28, w_y28;
    logic signed [35:0] w_x36, w_x2_36;
    logic signed [47:0] w_x2_48;
    logic signed [39:0] w_x2_40, w_y40;

    logic signed [56:0] r_spow [0:4];
    logic signed [49:0] r_smom [0:2];

    logic [63:0]  w_elem;
    logic [127:0] r_mul_a, r_mul_b, r_mul_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic         r_ppv, r_mbusy, r_mul_done;
    logic [3:0]   r_mcnt;
    logic [3:0]   w_pair;
    logic [127:0] w_pp_wide;

    logic [127:0] r_det, r_den;

    logic         r_dbusy, r_div_done, r_dneg, r_sat;
    logic [7:0]   r_dcnt;
    logic [143:0] r_dn;
    logic [127:0] r_dd, r_rem;
    logic [50:0]  r_q;
    logic [127:0] w_num_abs, w_den_abs;
    logic [128:0] w_rsh, w_tw;
    logic         w_ge, w_rup;
    logic [50:0]  w_qsh, w_qr, w_qneg;
    logic [47:0]  w_res;

    logic signed [47:0] r_coef0, r_coef1, r_coef2;
    logic signed [47:0] r_o_c0, r_o_c1, r_o_c2;
    logic               r_o_sing, r_o_ovf;

    // normal matrix entry, padded with identity, one column optionally replaced
    function automatic logic [63:0] f_elem(input logic [1:0] r, input logic [1:0] c,
                                           input logic [1:0] ord, input logic [1:0] col,
                                           input logic [1:0] kk);
        logic [2:0] idx;
        idx = {1'b0, r} + {1'b0, c};
        if (col != plsf_pkg::COL_NONE && c == col) begin
            return (r < kk) ? 64'(r_smom[r]) : 64'd0;
        end else if (r < ord && c < ord) begin
            return 64'(r_spow[idx]);
        end else begin
            return (r == c) ? 64'd1 : 64'd0;
        end
    endfunction

    // sample counting with capacity limit
    assign w_take = i_acc && (r_cnt < CW'(MAX_SAMPLES));

    // operand extension for the product stages
    assign w_x28 = 28'(i_sample_x);
    assign w_y28 = 28'(i_sample_y);
    assign w_x36 = 36'(r_s1_x);
    assign w_x2_36 = 36'(r_s1_x2);
    assign w_x2_48 = 48'(r_s1_x2);
    assign w_x2_40 = 40'(r_s1_x2);
    assign w_y40 = 40'(r_s1_y);

    // stage one: x^2 and x*y
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_take;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_x <= i_sample_x;
        r_s1_y <= i_sample_y;
        r_s1_x2 <= 24'(i_sample_x) * 24'(i_sample_x);
        r_s1_xy <= w_x28 * w_y28;
        // stage two: x^3, x^4 and x^2*y
        r_s2_x <= r_s1_x;
        r_s2_y <= r_s1_y;
        r_s2_x2 <= r_s1_x2;
        r_s2_xy <= r_s1_xy;
        r_s2_x3 <= w_x2_36 * w_x36;
        r_s2_x4 <= w_x2_48 * w_x2_48;
        r_s2_x2y <= w_x2_40 * w_y40;
    end

    // stage three: power and moment sums, count, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            for (int i = 0; i < 5; i++) r_spow[i] <= '0;
            for (int i = 0; i < 3; i++) r_smom[i] <= '0;
        end else begin
            if (w_take) r_cnt <= r_cnt + CW'(1);
            else if (i_acc) r_ovf <= 1'b1;
            if (r_s2_vld) begin
                r_spow[0] <= r_spow[0] + 57'sd1;
                r_spow[1] <= r_spow[1] + 57'(r_s2_x);
                r_spow[2] <= r_spow[2] + 57'(r_s2_x2);
                r_spow[3] <= r_spow[3] + 57'(r_s2_x3);
                r_spow[4] <= r_spow[4] + 57'(r_s2_x4);
                r_smom[0] <= r_smom[0] + 50'(r_s2_y);
                r_smom[1] <= r_smom[1] + 50'(r_s2_xy);
                r_smom[2] <= r_smom[2] + 50'(r_s2_x2y);
            end
        end
    end

    // one matrix entry per cycle, selected combinationally; the multiplier loads it on load_a or mul_start
    always_comb begin
        w_elem = f_elem(i_cmd.row, plsf_pkg::f_perm_col(i_cmd.perm, i_cmd.row),
                        i_cmd.ord, i_cmd.col, i_cmd.kk);
    end

    // multiplier: 32x32 partial products, mod 2^128
    assign w_pair = plsf_pkg::f_pair(r_mcnt);
    assign w_pp_wide = {64'd0, r_pp} << {r_psh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mul_done <= 1'b0;
            r_ppv <= 1'b0;
            r_mcnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
            r_mul_done <= 1'b0;
            r_ppv <= 1'b0;
            r_mcnt <= '0;
        end else if (r_mbusy) begin
            r_ppv <= (r_mcnt < plsf_pkg::MUL_PAIRS);
            r_mcnt <= r_mcnt + 4'd1;
            if (r_mcnt == plsf_pkg::MUL_PAIRS) begin
                r_mbusy <= 1'b0;
                r_mul_done <= 1'b1;
            end
        end else begin
            r_mul_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) r_mul_a <= {{64{w_elem[63]}}, w_elem};
        if (i_cmd.mul_start) begin
            if (i_cmd.mul_chain) r_mul_a <= r_mul_acc;
            r_mul_b <= {{64{w_elem[63]}}, w_elem};
            r_mul_acc <= '0;
        end else if (r_mbusy) begin
            r_pp <= r_mul_a[32*w_pair[3:2] +: 32] * r_mul_b[32*w_pair[1:0] +: 32];
            r_psh <= w_pair[3:2] + w_pair[1:0];
            if (r_ppv) r_mul_acc <= r_mul_acc + w_pp_wide;
        end
    end

    // determinant accumulator and saved divisor
    always_ff @(posedge i_clk) begin
        if (i_cmd.det_clr) begin
            r_det <= '0;
        end else if (i_cmd.det_add) begin
            if (plsf_pkg::f_perm_neg(i_cmd.perm)) r_det <= r_det - r_mul_acc;
            else r_det <= r_det + r_mul_acc;
        end
        if (i_cmd.den_save) r_den <= r_det;
    end

    // divider: one quotient bit per cycle, then rounding and saturation
    assign w_num_abs = r_det[127] ? (~r_det + 128'd1) : r_det;
    assign w_den_abs = r_den[127] ? (~r_den + 128'd1) : r_den;
    assign w_rsh = {r_rem, r_dn[143]};
    assign w_ge = (w_rsh >= {1'b0, r_dd});
    assign w_qsh = {r_q[49:0], w_ge};
    assign w_tw = {r_rem, 1'b0};
    assign w_rup = (w_tw >= {1'b0, r_dd});
    assign w_qr = r_q + {50'd0, w_rup};
    assign w_qneg = 51'd0 - w_qr;

    always_comb begin
        if (r_dneg) begin
            w_res = (r_sat || w_qr > plsf_pkg::Q_LIM) ? plsf_pkg::COEF_MIN : w_qneg[47:0];
        end else begin
            w_res = (r_sat || w_qr > plsf_pkg::Q_LIM - 51'd1) ? plsf_pkg::COEF_MAX
                                                              : w_qr[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_div_done <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_div_done <= 1'b0;
            r_dcnt <= '0;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + 8'd1;
            if (r_dcnt == plsf_pkg::DIV_STEPS) begin
                r_dbusy <= 1'b0;
                r_div_done <= 1'b1;
            end
        end else begin
            r_div_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dn <= {w_num_abs, 16'd0};
            r_dd <= w_den_abs;
            r_rem <= '0;
            r_q <= '0;
            r_sat <= 1'b0;
            r_dneg <= r_det[127] ^ r_den[127];
        end else if (r_dbusy && r_dcnt < plsf_pkg::DIV_STEPS) begin
            r_dn <= {r_dn[142:0], 1'b0};
            r_rem <= w_ge ? 128'(w_rsh - {1'b0, r_dd}) : w_rsh[127:0];
            if (w_qsh >= plsf_pkg::Q_SAT) begin
                r_q <= plsf_pkg::Q_SAT;
                r_sat <= 1'b1;
            end else begin
                r_q <= w_qsh;
            end
        end
    end

    // coefficient registers, cleared on solve_init and written when a division finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.solve_init) begin
            r_coef0 <= '0;
            r_coef1 <= '0;
            r_coef2 <= '0;
        end else if (r_dbusy && r_dcnt == plsf_pkg::DIV_STEPS) begin
            case (i_cmd.col)
                2'd0:    r_coef0 <= w_res;
                2'd1:    r_coef1 <= w_res;
                2'd2:    r_coef2 <= w_res;
                default: r_coef0 <= r_coef0;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_c0 <= r_coef0;
            r_o_c1 <= r_coef1;
            r_o_c2 <= r_coef2;
            r_o_sing <= i_cmd.sing;
            r_o_ovf <= r_ovf;
        end
    end

    assign o_sts.mul_done = r_mul_done;
    assign o_sts.div_done = r_div_done;
    assign o_sts.det_zero = (r_det == 128'd0);
    assign o_coef_const = r_o_c0;
    assign o_coef_linear = r_o_c1;
    assign o_coef_quad = r_o_c2;
    assign o_singular = r_o_sing;
    assign o_sample_overflow = r_o_ovf;

endmodule

### tb/polynomial_least_squares_fit_checker.sv
// checker of the polynomial fit block: watches the sample, result and register channels,
// predicts each fit exactly and compares it field by field; depends on nothing else
module polynomial_least_squares_fit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [11:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic               i_last_sample,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [47:0] i_coef_const,
    input  logic signed [47:0] i_coef_linear,
    input  logic signed [47:0] i_coef_quad,
    input  logic               i_singular,
    input  logic               i_sample_overflow,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_failures,
    output int                 o_pending
);
    localparam int SAMPLE_CAP = 4096;
    localparam logic [0:0] IDX_NUM_TERMS = 1'b0;

    typedef logic signed [127:0] wide_t;
    typedef wide_t mat_t [3][3];

    typedef struct packed {
        logic [47:0] c0;
        logic [47:0] c1;
        logic [47:0] c2;
        logic        sing;
        logic        ovf;
    } fit_t;

    fit_t   fit_q[$];
    logic [1:0] terms;
    int     n_samples;
    longint pow_sum [5];
    longint mom_sum [3];
    logic   ovf_seen;
    int     failures;

    // 3x3 determinant modulo 2^128
    function automatic wide_t det3(mat_t m);
        wide_t c0, c1, c2;
        c0 = m[1][1] * m[2][2] - m[1][2] * m[2][1];
        c1 = m[1][0] * m[2][2] - m[1][2] * m[2][0];
        c2 = m[1][0] * m[2][1] - m[1][1] * m[2][0];
        return m[0][0] * c0 - m[0][1] * c1 + m[0][2] * c2;
    endfunction

    // normal matrix of order k padded with identity
    function automatic mat_t normal_mat(int k);
        mat_t m;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (i < k && j < k) ? wide_t'(pow_sum[i + j]) : ((i == j) ? 1 : 0);
        return m;
    endfunction

    // num * 2^16 / den rounded half away from zero, saturated to 48 bits
    function automatic logic [47:0] q16_round(wide_t num, wide_t den);
        logic [127:0] n, d;
        logic [143:0] sh, qf, rm;
        logic [63:0]  q;
        logic         neg, sat;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        sh = {n, 16'b0};
        qf = sh / {16'b0, d};
        rm = sh % {16'b0, d};
        sat = qf >= (144'd1 << 49);
        q = qf[63:0];
        if (!sat && ({1'b0, rm} << 1) >= {17'b0, d})
            q = q + 1;
        if (neg) begin
            if (sat || q > (64'd1 << 47))
                q = 64'd1 << 47;
            return -q[47:0];
        end
        if (sat || q > (64'd1 << 47) - 1)
            q = (64'd1 << 47) - 1;
        return q[47:0];
    endfunction

    // solve the accumulated set and clear the sums
    function automatic fit_t solve_set();
        fit_t  f;
        mat_t  m, mj;
        wide_t den;
        wide_t rhs [3];
        logic [47:0] c [3];
        int    k;
        k = (terms == 0) ? 1 : terms;
        f.sing = 1'b0;
        for (int j = 1; j <= k; j++)
            if (det3(normal_mat(j)) == 0)
                f.sing = 1'b1;
        m = normal_mat(k);
        den = det3(m);
        for (int i = 0; i < 3; i++)
            rhs[i] = (i < k) ? wide_t'(mom_sum[i]) : 0;
        for (int j = 0; j < 3; j++) begin
            c[j] = '0;
            if (!f.sing && j < k) begin
                mj = m;
                for (int r = 0; r < 3; r++)
                    mj[r][j] = rhs[r];
                c[j] = q16_round(det3(mj), den);
            end
        end
        f.c0 = c[0];
        f.c1 = c[1];
        f.c2 = c[2];
        f.ovf = ovf_seen;
        n_samples = 0;
        ovf_seen = 1'b0;
        foreach (pow_sum[i]) pow_sum[i] = 0;
        foreach (mom_sum[i]) mom_sum[i] = 0;
        return f;
    endfunction

    assign o_failures = failures;
    assign o_pending  = fit_q.size();

    always @(posedge i_clk) begin
        fit_t   got, want;
        longint p;
        if (!i_rst_n) begin
            terms = 2'd3;
            n_samples = 0;
            ovf_seen = 1'b0;
            foreach (pow_sum[i]) pow_sum[i] = 0;
            foreach (mom_sum[i]) mom_sum[i] = 0;
            fit_q.delete();
        end else begin
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00
                && i_paddr[2] == IDX_NUM_TERMS)
                terms = i_pwdata[1:0];
            // accepted sample item
            if (i_in_valid && i_in_ready) begin
                if (n_samples < SAMPLE_CAP) begin
                    p = 1;
                    for (int i = 0; i < 5; i++) begin
                        pow_sum[i] += p;
                        if (i < 3)
                            mom_sum[i] += p * longint'(i_sample_y);
                        p *= longint'(i_sample_x);
                    end
                    n_samples++;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (i_last_sample)
                    fit_q.push_back(solve_set());
            end
            // accepted result item
            if (i_out_valid && i_out_ready) begin
                got = '{i_coef_const, i_coef_linear, i_coef_quad, i_singular,
                        i_sample_overflow};
                if (fit_q.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result item: %p", got);
                end else begin
                    want = fit_q.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: want c0=%h c1=%h c2=%h sing=%b ovf=%b, got c0=%h c1=%h c2=%h sing=%b ovf=%b",
                                     want.c0, want.c1, want.c2, want.sing, want.ovf,
                                     got.c0, got.c1, got.c2, got.sing, got.ovf);
                    end
                end
            end
        end
    end

    initial failures = 0;
endmodule

### tb/polynomial_least_squares_fit_test.sv
// testbench top of the polynomial fit block: clock, reset, samples, register writes, verdict
// depends on polynomial_least_squares_fit and polynomial_least_squares_fit_checker
module polynomial_least_squares_fit_test;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SAMPLE_OVER = 4100;
    localparam logic [2:0] ADDR_NUM_TERMS = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [11:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [47:0] coef_const, coef_linear, coef_quad;
    logic               singular, sample_overflow;
    logic               psel, penable, pwrite, pready;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    int                 failures, pending;
    logic               in_taken, out_taken;
    logic               calm_in, calm_out;
    int                 cycles, n_items, n_sets;

    polynomial_least_squares_fit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_sample_x(sample_x), .i_sample_y(sample_y), .i_last_sample(last_sample),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_coef_const(coef_const), .o_coef_linear(coef_linear), .o_coef_quad(coef_quad),
        .o_singular(singular), .o_sample_overflow(sample_overflow),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    polynomial_least_squares_fit_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_sample_x(sample_x), .i_sample_y(sample_y), .i_last_sample(last_sample),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_coef_const(coef_const), .i_coef_linear(coef_linear), .i_coef_quad(coef_quad),
        .i_singular(singular), .i_sample_overflow(sample_overflow),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_failures(failures), .o_pending(pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // handshakes seen at the rising edge, used at the next falling edge
    always @(posedge clk) begin
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side stalls, drawn per result item
    initial begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (out_taken) begin
                calm_out = ($urandom_range(0, 5) == 0) ? ~calm_out : calm_out;
                stall = calm_out ? 0 : $urandom_range(0, 14);
            end
            if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    // one sample item, starting and ending at a falling edge
    task automatic send_sample(input logic signed [11:0] x, input logic signed [15:0] y,
                               input logic last);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample_x = x;
        sample_y = y;
        last_sample = last;
        n_items++;
        do @(negedge clk); while (!in_taken);
    endtask

    // register write: setup then access
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // let every pending fit come out, then wait with the input idle
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // x drawn from one of several spreads
    function automatic logic signed [11:0] pick_x(int mode);
        case (mode)
            0:       return 12'($urandom);
            1:       return 12'($signed($urandom_range(0, 16)) - 8);
            2:       return $urandom_range(0, 1) ? 12'sh7ff : 12'sh800;
            default: return 12'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // one data set of random samples
    task automatic send_set(input int len);
        int mode;
        logic signed [11:0] x0;
        mode = $urandom_range(0, 4);
        x0 = pick_x(0);
        for (int i = 0; i < len; i++)
            send_sample((mode == 4) ? x0 : pick_x(mode), 16'($urandom), i == len - 1);
        n_sets++;
    endtask

    initial begin
        int len;
        cycles = 0;
        n_items = 0;
        n_sets = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_x = '0;
        sample_y = '0;
        last_sample = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // quadratic through extreme points, at reset setting
        send_sample(12'sh800, 16'sh8000, 1'b0);
        send_sample(12'sh7ff, 16'sh7fff, 1'b0);
        send_sample(12'sh000, 16'sh8000, 1'b0);
        send_sample(12'sh001, 16'sh7fff, 1'b1);
        // single sample: quadratic system is singular
        send_sample(12'sh005, 16'sh1234, 1'b1);
        // repeated x: singular at order two
        send_sample(12'sh7ff, 16'sh0001, 1'b0);
        send_sample(12'sh7ff, 16'shffff, 1'b1);
        drain();
        // linear fit
        reg_write(ADDR_NUM_TERMS, 32'd2);
        send_sample(12'sh000, 16'sh7fff, 1'b0);
        send_sample(12'sh001, 16'sh8000, 1'b1);
        send_sample(12'sh800, 16'sh0000, 1'b1);
        drain();
        // constant fit, then zero terms acting as one
        reg_write(ADDR_NUM_TERMS, 32'd1);
        send_sample(12'sh123, 16'sh7fff, 1'b0);
        send_sample(12'sh800, 16'sh7ffe, 1'b1);
        drain();
        reg_write(ADDR_NUM_TERMS, 32'hffff_fffc);
        send_sample(12'sh7ff, 16'sh8000, 1'b1);
        drain();
        // unknown register is ignored
        reg_write(ADDR_UNUSED, 32'd1);
        send_sample(12'sh002, 16'sh0100, 1'b1);
        drain();

        // full capacity: samples past the limit are dropped
        reg_write(ADDR_NUM_TERMS, 32'd3);
        calm_in = 1'b1;
        send_set(SAMPLE_OVER);
        calm_in = 1'b0;
        drain();

        // random phases, each with its own term count
        while (n_items < 1500 + SAMPLE_OVER + 20) begin
            reg_write(ADDR_NUM_TERMS, $urandom_range(0, 3));
            for (int s = 0; s < 8; s++) begin
                calm_in = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200)
                                                   : $urandom_range(1, 12);
                send_set(len);
            end
            drain();
        end

        drain();
        repeat (50) @(negedge clk);
        $display("covered %0d sample items in %0d data sets, term counts 0 to 3,",
                 n_items, n_sets);
        $display("capacity overflow, singular systems and random stalls on both channels");
        if (failures == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures, %0d fits still pending", failures, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/plsf_pkg.sv
rtl/plsf_ctrl.sv
rtl/plsf_dp.sv
rtl/polynomial_least_squares_fit.sv
tb/polynomial_least_squares_fit_checker.sv
tb/polynomial_least_squares_fit_test.sv
